// ===== design/two_machine_flow_shop_makespan_top_macros.svh =====
// Assertion macros for the two-machine flow shop makespan block.
// Used by files that assert; each expects clk and rst_n in scope.
`ifndef TWO_MACHINE_FLOW_SHOP_MAKESPAN_TOP_MACROS_SVH
`define TWO_MACHINE_FLOW_SHOP_MAKESPAN_TOP_MACROS_SVH

// same-cycle implication
`define TMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tms assertion failed");

// next-cycle implication
`define TMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tms assertion failed");

`endif

// ===== design/tms_pkg.sv =====
// Shared types, constants and the Johnson ordering function.
// No dependencies.
package tms_pkg;

  localparam int TIME_W = 16;
  localparam int SPAN_W = 25;
  localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } job_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  // true if job x must run strictly before job y
  function automatic logic goes_before(input job_t x, input job_t y);
    logic x_first;
    logic y_first;
    logic res;
    x_first = x.a < x.b;
    y_first = y.a < y.b;
    if (x_first != y_first) begin
      res = x_first;
    end else if (x_first) begin
      res = x.a < y.a;
    end else begin
      res = x.b > y.b;
    end
    return res;
  endfunction

endpackage

// ===== design/tms_if.sv =====
// Valid/ready channel interfaces for jobs and makespan results.
// Depends on tms_pkg.
interface tms_job_if;
  logic                      valid;
  logic                      ready;
  logic [tms_pkg::TIME_W-1:0] time_on_first;
  logic [tms_pkg::TIME_W-1:0] time_on_second;
  logic                      job_last;

  modport source (output valid, time_on_first, time_on_second, job_last, input ready);
  modport sink (input valid, time_on_first, time_on_second, job_last, output ready);
endinterface

interface tms_span_if;
  logic                      valid;
  logic                      ready;
  logic [tms_pkg::SPAN_W-1:0] makespan;
  logic                      overflow;

  modport source (output valid, makespan, overflow, input ready);
  modport sink (input valid, makespan, overflow, output ready);
endinterface

// ===== design/tms_cell.sv =====
// One sorter cell: holds a job, inserts by Johnson order, shifts on sweep.
// Depends on tms_pkg.
module tms_cell (
  input  logic                clk,
  input  tms_pkg::cell_ctrl_t ctrl,
  input  tms_pkg::job_t       job_new,
  input  logic                occ,
  input  logic                left_before,
  input  tms_pkg::job_t       left_job,
  input  tms_pkg::job_t       right_job,
  output tms_pkg::job_t       job_q,
  output logic                ahead
);
  import tms_pkg::*;

  job_t job_r;
  job_t job_nxt;

  assign ahead = !occ || goes_before(job_new, job_r);
  assign job_q = job_r;

  always_comb begin
    job_nxt = job_r;
    if (ctrl.shift) begin
      job_nxt = right_job;
    end else if (ctrl.ins && ahead) begin
      job_nxt = left_before ? left_job : job_new;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

// ===== design/tms_acc.sv =====
// Two-stage makespan accumulator: A-finish prefix, then B-finish update.
// Depends on tms_pkg.
module tms_acc #(
  parameter int ACC_W = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      take,
  input  tms_pkg::job_t             job,
  output logic                      pending,
  output logic [tms_pkg::SPAN_W-1:0] span
);
  import tms_pkg::*;

  localparam int CMP_W = (ACC_W > SPAN_W) ? ACC_W : SPAN_W;

  logic [ACC_W-1:0]  fa_r, fa_nxt;
  logic [ACC_W-1:0]  fb_r, fb_nxt;
  logic [TIME_W-1:0] b_r;
  logic              s1_v_r, s1_v_nxt;
  logic [ACC_W-1:0]  fmax;
  logic [CMP_W-1:0]  fb_wide;

  assign fmax    = (fa_r > fb_r) ? fa_r : fb_r;
  assign fb_wide = CMP_W'(fb_r);
  assign span    = (fb_wide > CMP_W'(SPAN_MAX)) ? SPAN_MAX : fb_wide[SPAN_W-1:0];
  assign pending = s1_v_r;

  always_comb begin
    fa_nxt   = fa_r;
    fb_nxt   = fb_r;
    s1_v_nxt = take;
    if (s1_v_r) begin
      fb_nxt = fmax + ACC_W'(b_r);
    end
    if (take) begin
      fa_nxt = fa_r + ACC_W'(job.a);
    end
    if (clear) begin
      fa_nxt   = '0;
      fb_nxt   = '0;
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fa_r <= fa_nxt;
    fb_r <= fb_nxt;
    if (take) begin
      b_r <= job.b;
    end
  end

endmodule

// ===== design/two_machine_flow_shop_makespan_top.sv =====
// Top level of the two-machine flow shop makespan block.
// Depends on tms_pkg, tms_if, tms_cell, tms_acc and the assertion macro header.
`include "two_machine_flow_shop_makespan_top_macros.svh"

// Jobs enter a row of MAX_JOBS sorter cells, one per cycle while filling, each placed
// at once in Johnson order; a job arriving when all cells hold jobs is dropped and
// flagged. After the job marked last, the row shifts out one job per cycle into a
// two-stage accumulator, and the result is then loaded into an output register once
// that register is free; no job is taken during the sweep or until that load. The
// result sits in the output register, and the next set may start while it waits.
module two_machine_flow_shop_makespan_top #(
  parameter int MAX_JOBS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  tms_job_if.sink    in_ch,
  tms_span_if.source out_ch
);
  import tms_pkg::*;

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int ACC_W = TIME_W + 1 + $clog2(MAX_JOBS);

  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0] span_r;
  logic             span_ovf_r;

  logic       accept, full, sweep_step, out_free, load_out;
  job_t       job_new;
  cell_ctrl_t ctrl;
  job_t       job_q  [MAX_JOBS];
  logic       ahead  [MAX_JOBS];
  logic       acc_pending;
  logic [SPAN_W-1:0] acc_span;

  assign in_ch.ready = (state_r == ST_FILL);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(MAX_JOBS));
  assign job_new     = '{a: in_ch.time_on_first, b: in_ch.time_on_second};
  assign sweep_step  = (state_r == ST_SWEEP) && (count_r != '0);
  assign ctrl        = '{ins: accept && !full, shift: sweep_step};
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (state_r == ST_PUSH) && out_free;

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    job_t left_job;
    job_t right_job;
    logic left_before;

    if (i == 0) begin : g_head
      assign left_job    = '0;
      assign left_before = 1'b0;
    end else begin : g_body
      assign left_job    = job_q[i-1];
      assign left_before = ahead[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_tail
      assign right_job = '0;
    end else begin : g_mid
      assign right_job = job_q[i+1];
    end

    tms_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .job_new     (job_new),
      .occ         (count_r > CNT_W'(i)),
      .left_before (left_before),
      .left_job    (left_job),
      .right_job   (right_job),
      .job_q       (job_q[i]),
      .ahead       (ahead[i])
    );
  end

  tms_acc #(
    .ACC_W (ACC_W)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (accept && in_ch.job_last),
    .take    (sweep_step),
    .job     (job_q[0]),
    .pending (acc_pending),
    .span    (acc_span)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_FILL: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.job_last) begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_step) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      span_r     <= acc_span;
      span_ovf_r <= ovf_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.makespan = span_r;
  assign out_ch.overflow = span_ovf_r;

  `TMS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_JOBS))
  `TMS_ASSERT_NEXT(a_last_sweeps, accept && in_ch.job_last, state_r == ST_SWEEP)
  `TMS_ASSERT_NEXT(a_sweep_count, sweep_step, count_r == $past(count_r) - CNT_W'(1))
  `TMS_ASSERT_NOW(a_push_drained, state_r == ST_PUSH, !acc_pending && count_r == '0)

endmodule

// ===== bench/tb_top.sv =====
// Testbench for two_machine_flow_shop_makespan_top: job sets are driven through the valid/ready
// channels and every makespan is checked against a Johnson-rule predictor in a scoreboard class.
// Depends on tms_pkg, tms_if and the design files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_JOBS       = 256;
  localparam int IDLE_PCT       = 16;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int JOB_TARGET     = 850;

  typedef struct packed {
    logic [tms_pkg::SPAN_W-1:0] makespan;
    logic                       overflow;
  } span_t;

  class makespan_scoreboard;
    tms_pkg::job_t johnson_order[$];
    span_t         pending_spans[$];
    int            capacity;
    bit            drop_seen;
    int            errors;
    int            jobs_noted;
    int            sets_closed;
    int            sets_dropped;
    int            spans_checked;

    function new(int cap);
      capacity = cap;
    endfunction

    function bit runs_ahead(tms_pkg::job_t x, tms_pkg::job_t y);
      bit x_early;
      bit y_early;
      x_early = x.a < x.b;
      y_early = y.a < y.b;
      if (x_early && y_early) return x.a < y.a;
      if (!x_early && !y_early) return x.b > y.b;
      return x_early;
    endfunction

    function int pending();
      return pending_spans.size();
    endfunction

    function void note_job(logic [tms_pkg::TIME_W-1:0] a, logic [tms_pkg::TIME_W-1:0] b,
                           logic last);
      tms_pkg::job_t  job;
      int             pos;
      longint unsigned fin_a;
      longint unsigned fin_b;
      span_t          span;
      job.a = a;
      job.b = b;
      jobs_noted++;
      if (johnson_order.size() >= capacity) begin
        drop_seen = 1'b1;
      end else begin
        pos = johnson_order.size();
        while (pos > 0 && runs_ahead(job, johnson_order[pos-1])) pos--;
        johnson_order.insert(pos, job);
      end
      if (last) begin
        fin_a = 0;
        fin_b = 0;
        foreach (johnson_order[i]) begin
          fin_a += johnson_order[i].a;
          fin_b = ((fin_a > fin_b) ? fin_a : fin_b) + johnson_order[i].b;
        end
        span.makespan = (fin_b > longint'(tms_pkg::SPAN_MAX)) ? tms_pkg::SPAN_MAX
                                                              : fin_b[tms_pkg::SPAN_W-1:0];
        span.overflow = drop_seen;
        pending_spans.push_back(span);
        sets_closed++;
        if (drop_seen) sets_dropped++;
        johnson_order.delete();
        drop_seen = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_span(logic [tms_pkg::SPAN_W-1:0] makespan, logic overflow);
      span_t want;
      spans_checked++;
      if (pending_spans.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, makespan %0d", makespan));
      end else begin
        want = pending_spans.pop_front();
        if (makespan !== want.makespan)
          report_mismatch($sformatf("makespan %0d, want %0d", makespan, want.makespan));
        if (overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", overflow, want.overflow));
      end
    endtask

    task flag_leftovers();
      while (pending_spans.size() != 0) begin
        report_mismatch($sformatf("missing makespan %0d", pending_spans[0].makespan));
        void'(pending_spans.pop_front());
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  tms_job_if  job_ch();
  tms_span_if span_ch();
  makespan_scoreboard sb;
  int jobs_sent;
  int quiet_cycles;

  two_machine_flow_shop_makespan_top #(.MAX_JOBS(MAX_JOBS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (job_ch),
    .out_ch (span_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && job_ch.valid === 1'b1 && job_ch.ready === 1'b1)
      sb.note_job(job_ch.time_on_first, job_ch.time_on_second, job_ch.job_last);
    if (rst_n && span_ch.valid === 1'b1 && span_ch.ready === 1'b1)
      sb.check_span(span_ch.makespan, span_ch.overflow);
  end

  always @(posedge clk) begin
    if (!rst_n || (job_ch.valid && job_ch.ready) || (span_ch.valid && span_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    span_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.spans_checked >= 20) begin
        span_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (sb.spans_checked >= 35 && sb.spans_checked < 50)
        span_ch.ready <= 1'b1;
      else
        span_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [tms_pkg::TIME_W-1:0] pick_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 16'($urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_job(input logic [tms_pkg::TIME_W-1:0] a,
                          input logic [tms_pkg::TIME_W-1:0] b, input logic last);
    bit gaps_on;
    gaps_on = (jobs_sent < 60 || jobs_sent >= 220);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      job_ch.valid <= 1'b0;
      @(negedge clk);
    end
    job_ch.valid          <= 1'b1;
    job_ch.time_on_first  <= a;
    job_ch.time_on_second <= b;
    job_ch.job_last       <= last;
    do @(posedge clk); while (job_ch.ready !== 1'b1);
    jobs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_spans();
    job_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int set_idx;
    int set_len;
    sb = new(MAX_JOBS);
    jobs_sent = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    job_ch.valid = 1'b0;
    job_ch.time_on_first = '0;
    job_ch.time_on_second = '0;
    job_ch.job_last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_job(16'd0, 16'd0, 1'b1);
    send_job(16'hffff, 16'hffff, 1'b1);
    send_job(16'hffff, 16'd0, 1'b1);
    send_job(16'd0, 16'hffff, 1'b1);
    send_job(16'd3, 16'd7, 1'b0);
    send_job(16'd1, 16'd9, 1'b0);
    send_job(16'd5, 16'd5, 1'b0);
    send_job(16'd8, 16'd2, 1'b0);
    send_job(16'd3, 16'd4, 1'b0);
    send_job(16'd6, 16'd2, 1'b0);
    send_job(16'd4, 16'd9, 1'b1);
    send_job(16'd2, 16'd5, 1'b0);
    send_job(16'd2, 16'd8, 1'b0);
    send_job(16'd7, 16'd3, 1'b0);
    send_job(16'd9, 16'd3, 1'b1);
    send_job(16'd0, 16'hffff, 1'b0);
    send_job(16'hfffe, 16'hffff, 1'b0);
    send_job(16'hffff, 16'd0, 1'b1);
    drain_spans();

    set_idx = 0;
    while (jobs_sent < JOB_TARGET) begin
      if (set_idx == 10)
        set_len = MAX_JOBS;
      else if (set_idx == 25)
        set_len = MAX_JOBS + 4;
      else if ($urandom_range(9) == 0)
        set_len = $urandom_range(9, 24);
      else
        set_len = $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++)
        send_job(pick_time(), pick_time(), k == set_len - 1);
      set_idx++;
    end

    drain_spans();
    repeat (8) @(negedge clk);
    sb.flag_leftovers();
    $display("Ran %0d jobs in %0d sets, %0d makespans checked, %0d sets over capacity",
             sb.jobs_noted, sb.sets_closed, sb.spans_checked, sb.sets_dropped);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
